// ===== rtl/core/ipv4rhf_pkg.sv =====
// Shared types and constants for the IPv4 receive header filter.
// Depends on nothing; every file of the block refers to it by scoped names.
package ipv4rhf_pkg;

  // Verdict codes
  localparam logic [2:0] VERDICT_CSUM_ERROR   = 3'd0;
  localparam logic [2:0] VERDICT_MALFORMED    = 3'd1;
  localparam logic [2:0] VERDICT_NOT_ADDR     = 3'd2;
  localparam logic [2:0] VERDICT_DELIVER_TCP  = 3'd3;
  localparam logic [2:0] VERDICT_IGNORED      = 3'd4;

  // Configuration register indexes
  localparam logic CFG_OWN_ADDRESS    = 1'b0;
  localparam logic CFG_SUBNET_BCAST   = 1'b1;

  localparam logic [31:0] ALL_ONES_ADDRESS = 32'hFFFF_FFFF;
  localparam logic [7:0]  PROTO_TCP        = 8'd6;

  // Input beat: one header word
  typedef struct packed {
    logic [15:0] header_word;
    logic        first_word;
  } hdr_beat_t;

  // Result beat: one verdict per header
  typedef struct packed {
    logic [2:0]  verdict;
    logic [31:0] source_address;
    logic [15:0] payload_length;
    logic [15:0] check_value;
  } result_beat_t;

  // Address filter settings
  typedef struct packed {
    logic [31:0] own_address;
    logic [31:0] subnet_broadcast;
  } filter_cfg_t;

  // Parsed header, handed from the parser to the verdict stage
  typedef struct packed {
    logic        short_ihl;
    logic [15:0] check;
    logic [15:0] total_length;
    logic [5:0]  hdr_bytes;
    logic [7:0]  protocol;
    logic [31:0] source;
    logic [31:0] destination;
  } hdr_record_t;

endpackage

// ===== rtl/core/ipv4rhf_parse.sv =====
// Front end: walks header words, keeps the ones-complement sum and captures fields.
// Emits one parsed record per header. Depends on ipv4rhf_pkg.
module ipv4rhf_parse (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  ipv4rhf_pkg::hdr_beat_t   beat,
  output logic                     rec_push,
  output ipv4rhf_pkg::hdr_record_t rec
);

  // Word positions within the header (word 0 is the first word)
  localparam logic [4:0] WORD_TOTAL_LEN = 5'd1;
  localparam logic [4:0] WORD_PROTOCOL  = 5'd4;
  localparam logic [4:0] WORD_SRC_HI    = 5'd6;
  localparam logic [4:0] WORD_SRC_LO    = 5'd7;
  localparam logic [4:0] WORD_DST_HI    = 5'd8;
  localparam logic [4:0] WORD_DST_LO    = 5'd9;

  // 16-bit ones-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      oc_add = s[15:0] + {15'd0, s[16]};
    end
  endfunction

  logic        in_header, in_header_next;
  logic [4:0]  word_index, word_index_next;
  logic [4:0]  header_words, header_words_next;
  logic [15:0] running_sum, running_sum_next;
  logic [15:0] total_length, total_length_next;
  logic [7:0]  protocol_number, protocol_number_next;
  logic [31:0] source_hold, source_hold_next;
  logic [31:0] destination_hold, destination_hold_next;

  logic [15:0] w;
  logic [3:0]  ihl;
  logic [5:0]  last_cmp;

  assign w   = beat.header_word;
  assign ihl = w[11:8];
  // index of this beat plus one, for the last-word test
  assign last_cmp = {1'b0, word_index} + 6'd2;

  // Next-state and record build
  always_comb begin
    in_header_next        = in_header;
    word_index_next       = word_index;
    header_words_next     = header_words;
    running_sum_next      = running_sum;
    total_length_next     = total_length;
    protocol_number_next  = protocol_number;
    source_hold_next      = source_hold;
    destination_hold_next = destination_hold;
    rec_push              = 1'b0;

    if (accept && beat.first_word) begin
      word_index_next = 5'd0;
      if (ihl < 4'd5) begin
        in_header_next    = 1'b0;
        header_words_next = 5'd0;
        running_sum_next  = 16'd0;
        rec_push          = 1'b1;
      end else begin
        in_header_next    = 1'b1;
        header_words_next = {ihl, 1'b0};
        running_sum_next  = w;
      end
    end else if (accept && in_header) begin
      word_index_next  = word_index + 5'd1;
      running_sum_next = oc_add(running_sum, w);
      case (word_index_next)
        WORD_TOTAL_LEN: total_length_next = w;
        WORD_PROTOCOL:  protocol_number_next = w[7:0];
        WORD_SRC_HI:    source_hold_next = {w, source_hold[15:0]};
        WORD_SRC_LO:    source_hold_next = {source_hold[31:16], w};
        WORD_DST_HI:    destination_hold_next = {w, destination_hold[15:0]};
        WORD_DST_LO:    destination_hold_next = {destination_hold[31:16], w};
        default: ;
      endcase
      if (last_cmp >= {1'b0, header_words}) begin
        in_header_next = 1'b0;
        rec_push       = 1'b1;
      end
    end
  end

  // Record takes the values as they stand after this beat
  always_comb begin
    rec.short_ihl    = beat.first_word;
    rec.check        = beat.first_word ? ~w : ~running_sum_next;
    rec.total_length = total_length_next;
    rec.hdr_bytes    = {header_words, 1'b0};
    rec.protocol     = protocol_number_next;
    rec.source       = source_hold_next;
    rec.destination  = destination_hold_next;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_header    <= 1'b0;
      word_index   <= 5'd0;
      header_words <= 5'd0;
      running_sum  <= 16'd0;
    end else begin
      in_header    <= in_header_next;
      word_index   <= word_index_next;
      header_words <= header_words_next;
      running_sum  <= running_sum_next;
    end
  end

  // Captured fields; every one is rewritten before a header completes
  always_ff @(posedge clk) begin
    total_length     <= total_length_next;
    protocol_number  <= protocol_number_next;
    source_hold      <= source_hold_next;
    destination_hold <= destination_hold_next;
  end

endmodule

// ===== rtl/core/ipv4rhf_queue.sv =====
// Short record queue between parser and verdict stage.
// Depends on ipv4rhf_pkg for the record type.
module ipv4rhf_queue #(
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  ipv4rhf_pkg::hdr_record_t wr_data,
  input  logic                     rd_en,
  output ipv4rhf_pkg::hdr_record_t rd_data,
  output logic                     full,
  output logic                     empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ipv4rhf_pkg::hdr_record_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  // Storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/ipv4rhf_judge.sv =====
// Back end: turns a parsed record into a verdict and holds it in the output register.
// Depends on ipv4rhf_pkg.
module ipv4rhf_judge (
  input  logic                      clk,
  input  logic                      rst,
  input  ipv4rhf_pkg::filter_cfg_t  cfg,
  input  logic                      rec_valid,
  input  ipv4rhf_pkg::hdr_record_t  rec,
  output logic                      rec_take,
  input  logic                      pop,
  output logic                      empty,
  output ipv4rhf_pkg::result_beat_t result
);

  logic                      out_valid;
  ipv4rhf_pkg::result_beat_t res_next;
  logic                      short_total;
  logic                      addressed;

  assign empty    = !out_valid;
  assign rec_take = rec_valid && (!out_valid || pop);

  assign short_total = rec.total_length < {10'd0, rec.hdr_bytes};
  assign addressed   = (rec.destination == cfg.own_address) ||
                       (rec.destination == cfg.subnet_broadcast) ||
                       (rec.destination == ipv4rhf_pkg::ALL_ONES_ADDRESS);

  // Verdict priority: short IHL, checksum, length, address, protocol
  always_comb begin
    res_next.check_value = rec.check;
    if (rec.short_ihl) begin
      res_next.verdict        = ipv4rhf_pkg::VERDICT_MALFORMED;
      res_next.source_address = 32'd0;
      res_next.payload_length = 16'd0;
    end else begin
      res_next.source_address = rec.source;
      res_next.payload_length = short_total ? 16'd0
                                            : rec.total_length - {10'd0, rec.hdr_bytes};
      if (rec.check != 16'd0) begin
        res_next.verdict = ipv4rhf_pkg::VERDICT_CSUM_ERROR;
      end else if (short_total) begin
        res_next.verdict = ipv4rhf_pkg::VERDICT_MALFORMED;
      end else if (!addressed) begin
        res_next.verdict = ipv4rhf_pkg::VERDICT_NOT_ADDR;
      end else if (rec.protocol == ipv4rhf_pkg::PROTO_TCP) begin
        res_next.verdict = ipv4rhf_pkg::VERDICT_DELIVER_TCP;
      end else begin
        res_next.verdict = ipv4rhf_pkg::VERDICT_IGNORED;
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (rec_take) begin
      result <= res_next;
    end
  end

endmodule

// ===== rtl/core/ipv4_receive_header_filter.sv =====
// Top level of the IPv4 receive header filter: config registers, parser, queue, verdict.
// Depends on ipv4rhf_pkg, ipv4rhf_parse, ipv4rhf_queue and ipv4rhf_judge.
//
//   channel   handshake            beat
//   -------   ------------------   ------------------------------------------
//   header    push / full          hdr: header_word, first_word
//   result    empty / pop          result: verdict, source, payload len, check
//   config    cfg_write            cfg_index, cfg_data (own addr, subnet bcast)
//
// One header word is taken per cycle while full is low. The edge that takes the
// last word of a header writes its record into the queue; the verdict register
// loads it from the queue once the output register is empty or being popped.
// Synchronous active-high reset empties the queue and output register and
// closes any open header. A stalled result side backs up through the record
// queue; full rises only once the queue holds QUEUE_DEPTH pending headers.
module ipv4_receive_header_filter #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  ipv4rhf_pkg::hdr_beat_t    hdr,
  output logic                      empty,
  input  logic                      pop,
  output ipv4rhf_pkg::result_beat_t result,
  input  logic                      cfg_write,
  input  logic                      cfg_index,
  input  logic [31:0]               cfg_data
);

  ipv4rhf_pkg::filter_cfg_t cfg;
  ipv4rhf_pkg::hdr_record_t rec_in, rec_out;
  logic                     accept;
  logic                     rec_push;
  logic                     rec_take;
  logic                     q_empty;

  assign accept = push && !full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_address      <= 32'd0;
      cfg.subnet_broadcast <= 32'hFFFF_FFFF;
    end else if (cfg_write) begin
      case (cfg_index)
        ipv4rhf_pkg::CFG_OWN_ADDRESS:  cfg.own_address      <= cfg_data;
        ipv4rhf_pkg::CFG_SUBNET_BCAST: cfg.subnet_broadcast <= cfg_data;
        default: ;
      endcase
    end
  end

  ipv4rhf_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .beat     (hdr),
    .rec_push (rec_push),
    .rec      (rec_in)
  );

  ipv4rhf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rec_push),
    .wr_data (rec_in),
    .rd_en   (rec_take),
    .rd_data (rec_out),
    .full    (full),
    .empty   (q_empty)
  );

  ipv4rhf_judge u_judge (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rec_valid (!q_empty),
    .rec       (rec_out),
    .rec_take  (rec_take),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for ipv4_receive_header_filter: header words in, verdicts out.
// Depends on ipv4rhf_pkg and the RTL; the expected verdicts come from a predictor kept here.

module tb_top;
  import ipv4rhf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_PRINTS  = 40;

  // Predictor of the filter plus the queue of verdicts still owed by the block
  class hdr_filter_board;
    logic [31:0]  own_addr;
    logic [31:0]  bcast_addr;
    logic [15:0]  csum;
    logic [4:0]   word_idx;
    logic [4:0]   hdr_words;
    logic [15:0]  tot_len;
    logic [7:0]   proto;
    logic [31:0]  src_addr;
    logic [31:0]  dst_addr;
    bit           hdr_open;
    result_beat_t verdict_q[$];
    int           errors;
    int           checked;
    int           verdict_seen[5];

    function new();
      own_addr   = '0;
      bcast_addr = ALL_ONES_ADDRESS;
      csum       = '0;
      word_idx   = '0;
      hdr_words  = '0;
      tot_len    = '0;
      proto      = '0;
      src_addr   = '0;
      dst_addr   = '0;
      hdr_open   = 1'b0;
      errors     = 0;
      checked    = 0;
      foreach (verdict_seen[i]) verdict_seen[i] = 0;
    endfunction

    // 16-bit ones-complement add, carry folded back in
    static function logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
    endfunction

    function void write_config(logic idx, logic [31:0] data);
      if (idx == CFG_OWN_ADDRESS) own_addr = data;
      else bcast_addr = data;
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    // Advance the header parser by one accepted beat
    function void note_beat(hdr_beat_t b);
      logic [3:0]   ihl;
      logic [15:0]  chk;
      logic [15:0]  hdr_bytes;
      bit           short_total;
      result_beat_t r;
      if (b.first_word) begin
        ihl      = b.header_word[11:8];
        tot_len  = '0;
        proto    = '0;
        src_addr = '0;
        dst_addr = '0;
        word_idx = '0;
        if (ihl < 4'd5) begin
          // short header length: immediate malformed verdict, nothing opened
          hdr_open  = 1'b0;
          csum      = '0;
          hdr_words = '0;
          r.verdict        = VERDICT_MALFORMED;
          r.source_address = '0;
          r.payload_length = '0;
          r.check_value    = ~b.header_word;
          verdict_q.push_back(r);
          return;
        end
        hdr_words = {ihl, 1'b0};
        csum      = b.header_word;
        hdr_open  = 1'b1;
        return;
      end
      // stray word outside a header
      if (!hdr_open) return;

      word_idx = word_idx + 5'd1;
      csum     = ones_add(csum, b.header_word);
      case (word_idx)
        5'd1: tot_len = b.header_word;
        5'd4: proto = b.header_word[7:0];
        5'd6: src_addr[31:16] = b.header_word;
        5'd7: src_addr[15:0] = b.header_word;
        5'd8: dst_addr[31:16] = b.header_word;
        5'd9: dst_addr[15:0] = b.header_word;
        default: ;
      endcase
      if (int'(word_idx) + 1 < int'(hdr_words)) return;

      // last header word: verdict in priority order
      hdr_open    = 1'b0;
      hdr_bytes   = 16'(hdr_words) << 1;
      chk         = ~csum;
      short_total = tot_len < hdr_bytes;
      if (chk != 16'd0) r.verdict = VERDICT_CSUM_ERROR;
      else if (short_total) r.verdict = VERDICT_MALFORMED;
      else if (dst_addr != own_addr && dst_addr != bcast_addr &&
               dst_addr != ALL_ONES_ADDRESS) r.verdict = VERDICT_NOT_ADDR;
      else if (proto == PROTO_TCP) r.verdict = VERDICT_DELIVER_TCP;
      else r.verdict = VERDICT_IGNORED;
      r.source_address = src_addr;
      r.payload_length = short_total ? 16'd0 : tot_len - hdr_bytes;
      r.check_value    = chk;
      verdict_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("mismatch: %s", msg);
    endtask

    // Compare one popped verdict with the oldest owed one
    task check_result(result_beat_t got);
      result_beat_t want;
      if (verdict_q.size() == 0) begin
        report($sformatf("result with none owed: verdict %0d src %h",
                         got.verdict, got.source_address));
        return;
      end
      want = verdict_q.pop_front();
      checked++;
      if (want.verdict <= VERDICT_IGNORED) verdict_seen[want.verdict]++;
      if (got.verdict !== want.verdict)
        report($sformatf("result %0d verdict %0d, want %0d",
                         checked, got.verdict, want.verdict));
      if (got.source_address !== want.source_address)
        report($sformatf("result %0d source %h, want %h",
                         checked, got.source_address, want.source_address));
      if (got.payload_length !== want.payload_length)
        report($sformatf("result %0d payload length %0d, want %0d",
                         checked, got.payload_length, want.payload_length));
      if (got.check_value !== want.check_value)
        report($sformatf("result %0d check %h, want %h",
                         checked, got.check_value, want.check_value));
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         push = 1'b0;
  logic         full;
  hdr_beat_t    hdr = '0;
  logic         empty;
  logic         pop = 1'b0;
  result_beat_t result;
  logic         cfg_write = 1'b0;
  logic         cfg_index = CFG_OWN_ADDRESS;
  logic [31:0]  cfg_data = '0;

  hdr_filter_board board;
  bit              quiet = 1'b0;
  int              beats_sent = 0;
  int              stall_left = 0;
  int              cycles = 0;

  ipv4_receive_header_filter u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .hdr       (hdr),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Edge sampling: results checked first, then the accepted header beat
  always @(posedge clk) begin
    if (!rst && pop && !empty) board.check_result(result);
    if (!rst && push && !full) board.note_beat(hdr);
  end

  // Result side: pop with random stall bursts
  initial begin
    forever begin
      @(negedge clk);
      if (stall_left > 0) stall_left--;
      else if (!quiet && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 3);
      pop = !rst && stall_left == 0;
    end
  end

  // One header beat; returns at the falling edge after acceptance
  task automatic send_beat(input logic [15:0] w, input logic f);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    hdr  = '{header_word: w, first_word: f};
    push = 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  // Wait out every owed verdict, then the pipeline latency
  task automatic settle();
    push = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    board.write_config(idx, data);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Build an IPv4 header with a good checksum, optionally damaged or cut short
  task automatic send_ipv4_header(input logic [3:0] ihl, input logic [15:0] tot_len,
                                  input logic [7:0] proto, input logic [31:0] src,
                                  input logic [31:0] dst, input bit corrupt,
                                  input int keep_words);
    logic [15:0] w [30];
    logic [15:0] s;
    int          n;
    int          k;
    n    = int'(ihl) * 2;
    w[0] = {(($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd4), ihl, 8'($urandom)};
    w[1] = tot_len;
    w[2] = 16'($urandom);
    w[3] = 16'($urandom);
    w[4] = {8'($urandom), proto};
    w[5] = '0;
    w[6] = src[31:16];
    w[7] = src[15:0];
    w[8] = dst[31:16];
    w[9] = dst[15:0];
    for (k = 10; k < n; k++) w[k] = 16'($urandom);
    s = w[0];
    for (k = 1; k < n; k++) s = hdr_filter_board::ones_add(s, w[k]);
    w[5] = ~s;
    if (corrupt) begin
      k    = $urandom_range(0, n - 1);
      w[k] = w[k] ^ (16'h1 << $urandom_range(0, 15));
    end
    if (keep_words > n) keep_words = n;
    for (k = 0; k < keep_words; k++) send_beat(w[k], k == 0);
  endtask

  // Mostly well-formed headers, with stray words, short IHL, cut-off and damaged headers
  task automatic random_traffic(input int beat_budget);
    int          start;
    int          pick;
    logic [3:0]  ihl;
    logic [15:0] hb;
    logic [15:0] tl;
    logic [7:0]  proto;
    logic [31:0] dst;
    int          keep;
    start = beats_sent;
    while (beats_sent - start < beat_budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        repeat ($urandom_range(1, 3)) send_beat(16'($urandom), 1'b0);
      end else if (pick < 9) begin
        send_beat({4'($urandom), 4'($urandom_range(0, 4)), 8'($urandom)}, 1'b1);
      end else begin
        case ($urandom_range(0, 3))
          0, 1:    ihl = 4'd5;
          2:       ihl = 4'($urandom_range(6, 8));
          default: ihl = 4'($urandom_range(9, 15));
        endcase
        hb = 16'(ihl) << 2;
        case ($urandom_range(0, 9))
          0:       tl = 16'($urandom);
          1:       tl = 16'($urandom_range(0, int'(hb) - 1));
          2:       tl = hb;
          3:       tl = 16'hFFFF;
          default: tl = hb + 16'($urandom_range(0, 1500));
        endcase
        proto = ($urandom_range(0, 1) == 0) ? PROTO_TCP : 8'($urandom);
        case ($urandom_range(0, 5))
          0:       dst = board.own_addr;
          1:       dst = board.bcast_addr;
          2:       dst = ALL_ONES_ADDRESS;
          3:       dst = board.own_addr ^ (32'h1 << $urandom_range(0, 31));
          default: dst = $urandom;
        endcase
        keep = (pick < 14) ? $urandom_range(1, int'(ihl) * 2 - 1) : 30;
        send_ipv4_header(ihl, tl, proto, $urandom, dst, $urandom_range(0, 9) == 0, keep);
      end
    end
  endtask

  // Main sequence
  initial begin
    int k;
    board = new();
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed, reset settings: stray word, short IHL, restart, extreme lengths
    send_beat(16'hFFFF, 1'b0);
    send_beat(16'h0000, 1'b1);
    send_beat(16'hF4FF, 1'b1);
    send_ipv4_header(4'd5, 16'd20, PROTO_TCP, 32'h0A00_0001, ALL_ONES_ADDRESS, 1'b0, 2);
    send_ipv4_header(4'd5, 16'hFFFF, PROTO_TCP, 32'hFFFF_FFFF, ALL_ONES_ADDRESS, 1'b0, 30);
    send_ipv4_header(4'd5, 16'd0, 8'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 30);
    random_traffic(330);

    settle();
    write_reg(CFG_OWN_ADDRESS, $urandom);
    write_reg(CFG_SUBNET_BCAST, $urandom);
    random_traffic(350);

    settle();
    write_reg(CFG_OWN_ADDRESS, 32'hFFFF_FFFF);
    write_reg(CFG_SUBNET_BCAST, 32'h0000_0000);
    random_traffic(300);

    settle();
    write_reg(CFG_OWN_ADDRESS, 32'h0000_0000);
    write_reg(CFG_SUBNET_BCAST, 32'h8000_0000);
    random_traffic(300);

    // closing stretch runs without idling on either side
    settle();
    write_reg(CFG_OWN_ADDRESS, $urandom);
    write_reg(CFG_SUBNET_BCAST, $urandom);
    quiet = 1'b1;
    random_traffic(400);
    push = 1'b0;

    for (k = 0; k < 2000 && board.pending() != 0; k++) @(negedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d verdicts never arrived", board.pending()));
    repeat (10) @(negedge clk);

    $display("run: %0d header beats in, %0d verdicts checked over five address settings",
             beats_sent, board.checked);
    $display("run: csum %0d, malformed %0d, not addressed %0d, tcp %0d, ignored %0d",
             board.verdict_seen[VERDICT_CSUM_ERROR], board.verdict_seen[VERDICT_MALFORMED],
             board.verdict_seen[VERDICT_NOT_ADDR], board.verdict_seen[VERDICT_DELIVER_TCP],
             board.verdict_seen[VERDICT_IGNORED]);
    if (board.errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
